// File: hw/rtl/rsb_pkg.sv
// Shared types and constants for the run-length sprite row blitter.
`timescale 1ns / 1ps
`default_nettype none
package rsb_pkg;

  localparam int ADDR_W     = 20;
  localparam int POS_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int CLIP_W     = 10;
  localparam int BUDGET_W   = 6;
  localparam int LIT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam int LINE_PITCH_DEF = 768;
  localparam int CELL_WIDTH_DEF = 22;

  localparam logic [CLIP_W-1:0] CLIP_TOP_RST    = 10'd209;
  localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RST = 10'd469;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 1'b1;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_BYTE  = 1'b1
  } rsb_op_t;

  typedef struct packed {
    rsb_op_t             op;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [BYTE_W-1:0]   data_byte;
  } rsb_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [BYTE_W-1:0] pixel_value;
  } rsb_pix_t;

endpackage
`default_nettype wire

// File: hw/rtl/rsb_cfg.sv
// Clip row registers, held as precomputed address bounds.
`timescale 1ns / 1ps
`default_nettype none
module rsb_cfg
  import rsb_pkg::*;
#(
  parameter int LINE_PITCH = LINE_PITCH_DEF,
  parameter int CMP_W      = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CLIP_W-1:0]    cfg_wdata,
  output logic      [CMP_W-1:0]     top_bound,
  output logic      [CMP_W-1:0]     bottom_bound
);

  logic [CMP_W-1:0] top_bound_r, bottom_bound_r;
  logic [CMP_W-1:0] wr_bound;

  // row times pitch, full width so the bounds never wrap
  assign wr_bound = CMP_W'(cfg_wdata) * CMP_W'(LINE_PITCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_bound_r    <= CMP_W'(CLIP_TOP_RST) * CMP_W'(LINE_PITCH);
      bottom_bound_r <= CMP_W'(CLIP_BOTTOM_RST) * CMP_W'(LINE_PITCH);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CLIP_TOP:    top_bound_r    <= wr_bound;
        CFG_CLIP_BOTTOM: bottom_bound_r <= wr_bound;
        default: ;
      endcase
    end
  end

  assign top_bound    = top_bound_r;
  assign bottom_bound = bottom_bound_r;

endmodule
`default_nettype wire

// File: hw/rtl/rsb_core.sv
// Run decoder: address, row budget and literal run state, one byte per beat.
`timescale 1ns / 1ps
`default_nettype none
module rsb_core
  import rsb_pkg::*;
#(
  parameter int LINE_PITCH = LINE_PITCH_DEF,
  parameter int CELL_WIDTH = CELL_WIDTH_DEF,
  parameter int CMP_W      = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire rsb_item_t        item,
  input  wire logic [CMP_W-1:0] top_bound,
  input  wire logic [CMP_W-1:0] bottom_bound,
  output logic                  emit,
  output rsb_pix_t              pix
);

  localparam logic [ADDR_W-1:0]   ROW_BACK     = ADDR_W'(LINE_PITCH + CELL_WIDTH);
  localparam logic [BUDGET_W-1:0] CELL_BUDGET  = BUDGET_W'(CELL_WIDTH);

  logic [ADDR_W-1:0]   addr_r, addr_nxt, addr_pre;
  logic [BUDGET_W-1:0] budget_r, budget_nxt, budget_open;
  logic [LIT_W-1:0]    lit_r, lit_nxt;
  logic                vis_r, vis_nxt;
  logic [BYTE_W-1:0]   run_len;
  logic [ADDR_W-1:0]   begin_full;
  logic                step;
  logic                addr_vis;

  // start address wraps at the address width
  assign begin_full  = ADDR_W'(item.pos_y) * ADDR_W'(LINE_PITCH) + ADDR_W'(item.pos_x);
  assign budget_open = (budget_r != '0) ? budget_r : CELL_BUDGET;
  assign addr_vis    = (CMP_W'(addr_r) >= top_bound) && (CMP_W'(addr_r) <= bottom_bound);
  // skip count is the byte negated; 0x80 gives 128
  assign run_len     = item.data_byte[BYTE_W-1] ? BYTE_W'(~item.data_byte + 8'd1)
                                                : item.data_byte;

  always_comb begin
    addr_pre   = addr_r;
    budget_nxt = budget_r;
    lit_nxt    = lit_r;
    vis_nxt    = vis_r;
    emit       = 1'b0;
    step       = 1'b0;
    if (item.op == OP_BEGIN) begin
      addr_pre   = begin_full;
      budget_nxt = '0;
      lit_nxt    = '0;
      vis_nxt    = 1'b0;
    end else if (lit_r != '0) begin
      emit     = vis_r;
      addr_pre = addr_r + ADDR_W'(1);
      lit_nxt  = lit_r - LIT_W'(1);
      step     = (lit_nxt == '0) && (budget_r == '0);
    end else begin
      if (item.data_byte[BYTE_W-1]) begin
        addr_pre = addr_r + ADDR_W'(run_len);
      end else begin
        lit_nxt = item.data_byte[LIT_W-1:0];
        vis_nxt = addr_vis;
      end
      // overshoot clamps the budget at zero
      if (run_len >= BYTE_W'(budget_open)) begin
        budget_nxt = '0;
      end else begin
        budget_nxt = budget_open - run_len[BUDGET_W-1:0];
      end
      step = (budget_nxt == '0) && (lit_nxt == '0);
    end
    addr_nxt = step ? (addr_pre - ROW_BACK) : addr_pre;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      budget_r <= '0;
      lit_r    <= '0;
      vis_r    <= 1'b0;
    end else if (advance) begin
      addr_r   <= addr_nxt;
      budget_r <= budget_nxt;
      lit_r    <= lit_nxt;
      vis_r    <= vis_nxt;
    end
  end

  assign pix.pixel_address = addr_r;
  assign pix.pixel_value   = item.data_byte;

  a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.op == OP_BEGIN |=> lit_r == '0 && budget_r == '0 && !vis_r)
    else $error("begin beat did not clear run state");

  a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> lit_r != '0 && vis_r && item.op == OP_BYTE)
    else $error("pixel emitted outside a visible literal run");

endmodule
`default_nettype wire

// File: hw/rtl/rle_sprite_row_blitter.sv
// A writing pixel byte beat is registered in the input stage, and its write is then registered
// in the output slot that drives out_tvalid.
// Throughput: one input beat per cycle while out_tready stays high; a begin beat,
// a control byte or a clipped pixel byte gives no output beat.
// While a result waits, input beats keep flowing until a writing pixel byte is held.
// Reset (rst_n low, synchronous) clears run state and address and loads clip rows 209/469.
`timescale 1ns / 1ps
`default_nettype none
module rle_sprite_row_blitter
  import rsb_pkg::*;
#(
  parameter int LINE_PITCH = LINE_PITCH_DEF,
  parameter int CELL_WIDTH = CELL_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // pos_x[9:0], pos_y[19:10], data_byte[27:20]
  input  wire logic                  in_tuser,  // operation: 0 begin, 1 frame byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata, // pixel_address[19:0], pixel_value[27:20]
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CLIP_W-1:0]     cfg_wdata
);

  localparam int PITCH_W = $clog2(LINE_PITCH + 1);
  localparam int BOUND_W = CLIP_W + PITCH_W;
  localparam int CMP_W   = (BOUND_W > ADDR_W) ? BOUND_W : ADDR_W;

  rsb_item_t        s1_r;
  logic             s1_valid_r;
  logic             s1_adv;
  logic             emit;
  rsb_pix_t         pix;
  rsb_pix_t         out_pix_r;
  logic             out_valid_r;
  logic [CMP_W-1:0] top_bound, bottom_bound;

  rsb_cfg #(
    .LINE_PITCH (LINE_PITCH),
    .CMP_W      (CMP_W)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .top_bound    (top_bound),
    .bottom_bound (bottom_bound)
  );

  rsb_core #(
    .LINE_PITCH (LINE_PITCH),
    .CELL_WIDTH (CELL_WIDTH),
    .CMP_W      (CMP_W)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (s1_adv),
    .item         (s1_r),
    .top_bound    (top_bound),
    .bottom_bound (bottom_bound),
    .emit         (emit),
    .pix          (pix)
  );

  // advance the held beat unless it needs the output slot and the slot is stuck
  assign s1_adv    = s1_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r.op        <= rsb_op_t'(in_tuser);
      s1_r.pos_x     <= in_tdata[POS_W-1:0];
      s1_r.pos_y     <= in_tdata[2*POS_W-1:POS_W];
      s1_r.data_byte <= in_tdata[2*POS_W+BYTE_W-1:2*POS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_pix_r <= pix;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - ADDR_W - BYTE_W){1'b0}},
                       out_pix_r.pixel_value, out_pix_r.pixel_address};

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && emit))
    else $error("output beat appeared without an emitting pixel byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready && emit |-> !s1_adv)
    else $error("pending output beat overwritten");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_r))
    else $error("held input beat lost or changed");

endmodule
`default_nettype wire

// File: test/rle_sprite_row_blitter_test.sv
// Self-checking testbench for the run-length sprite row blitter: coded frames in, pixel writes out.
`timescale 1ns / 1ps
module rle_sprite_row_blitter_test;
  import rsb_pkg::*;

  localparam int PITCH       = LINE_PITCH_DEF;
  localparam int CELL        = CELL_WIDTH_DEF;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SLOW, RX_COMB} rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CLIP_W-1:0]     cfg_wdata = '0;

  rle_sprite_row_blitter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rsb_item_t pending_beats[$];
  rsb_pix_t  expected_writes[$];

  // Decoder state mirrored from the block
  logic [ADDR_W-1:0]   draw_addr = '0;
  logic [BUDGET_W-1:0] row_left = '0;
  logic [LIT_W-1:0]    lit_left = '0;
  logic                run_shown = 1'b0;
  logic [CLIP_W-1:0]   clip_top = CLIP_TOP_RST;
  logic [CLIP_W-1:0]   clip_bot = CLIP_BOTTOM_RST;

  logic      in_fire = 1'b0;
  int        cycle_count = 0;
  int        fail_count = 0;
  int        beats_taken = 0;
  int        pixels_seen = 0;
  int        sprite_starts = 0;
  int        clip_settings = 1;
  int        burst_left = 0;
  int        idle_left = 0;
  int        rx_left = 0;
  int        rx_tick = 0;
  rx_style_t rx_style = RX_STEADY;

  function automatic logic visible_at(input logic [ADDR_W-1:0] addr);
    return int'(addr) >= int'(clip_top) * PITCH && int'(addr) <= int'(clip_bot) * PITCH;
  endfunction

  // Advance the mirrored decoder by one beat; queue a pixel write when one is due
  task automatic decode_beat(input rsb_item_t it);
    int budget;
    int n;
    rsb_pix_t px;
    if (it.op == OP_BEGIN) begin
      draw_addr = ADDR_W'(int'(it.pos_y) * PITCH + int'(it.pos_x));
      row_left  = '0;
      lit_left  = '0;
      run_shown = 1'b0;
      sprite_starts++;
    end else if (lit_left != 0) begin
      if (run_shown) begin
        px.pixel_address = draw_addr;
        px.pixel_value   = it.data_byte;
        expected_writes.push_back(px);
      end
      draw_addr = draw_addr + ADDR_W'(1);
      lit_left  = lit_left - LIT_W'(1);
      if (lit_left == 0 && row_left == 0) draw_addr = draw_addr - ADDR_W'(PITCH + CELL);
    end else begin
      budget = (row_left != 0) ? int'(row_left) : CELL;
      if (it.data_byte[7]) begin
        n = 256 - int'(it.data_byte);
        draw_addr = draw_addr + ADDR_W'(n);
      end else begin
        n = int'(it.data_byte);
        lit_left  = LIT_W'(n);
        run_shown = visible_at(draw_addr);
      end
      row_left = (n >= budget) ? '0 : BUDGET_W'(budget - n);
      if (row_left == 0 && lit_left == 0) draw_addr = draw_addr - ADDR_W'(PITCH + CELL);
    end
  endtask

  task automatic queue_beat(input rsb_op_t op, input int x, input int y, input int b);
    rsb_item_t it;
    it.op        = op;
    it.pos_x     = POS_W'(x);
    it.pos_y     = POS_W'(y);
    it.data_byte = BYTE_W'(b);
    pending_beats.push_back(it);
  endtask

  task automatic queue_begin(input int x, input int y);
    queue_beat(OP_BEGIN, x, y, $urandom_range(0, 255));
  endtask

  task automatic queue_byte(input int b);
    queue_beat(OP_BYTE, $urandom_range(0, 767), $urandom_range(0, 1023), b);
  endtask

  // Mostly whole sprites with random runs, some cut short, the rest noise
  task automatic add_random_stream(input int goal);
    int added;
    int rows;
    int left;
    int n;
    int y;
    bit cut;
    added = 0;
    while (added < goal) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 3))
          0: y = int'(clip_top) + $urandom_range(0, 8);
          1: y = int'(clip_bot) + $urandom_range(0, 10) - 2;
          default: y = $urandom_range(0, 1023);
        endcase
        if (y > 1023) y = 1023;
        queue_begin($urandom_range(0, 767), y);
        added++;
        rows = $urandom_range(1, 8);
        cut = 1'b0;
        for (int r = 0; r < rows && !cut; r++) begin
          left = CELL;
          while (left > 0 && !cut) begin
            if ($urandom_range(0, 99) < 35) begin
              n = $urandom_range(1, ($urandom_range(0, 19) == 0) ? 128 : left);
              queue_byte(256 - n);
              added++;
            end else begin
              n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(0, left);
              queue_byte(n);
              added++;
              for (int k = 0; k < n && !cut; k++) begin
                queue_byte($urandom_range(0, 255));
                added++;
                if ($urandom_range(0, 299) == 0) cut = 1'b1;
              end
            end
            left -= n;
            if ($urandom_range(0, 99) == 0) cut = 1'b1;
          end
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_beat(rsb_op_t'($urandom_range(0, 1)), $urandom_range(0, 767),
                     $urandom_range(0, 1023), $urandom_range(0, 255));
          added++;
        end
      end
    end
  endtask

  // Hold off until every beat is taken and every pixel write has come back
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_clip(input int top, input int bottom);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CLIP_TOP;
    cfg_wdata <= CLIP_W'(top);
    @(negedge clk);
    cfg_addr  <= CFG_CLIP_BOTTOM;
    cfg_wdata <= CLIP_W'(bottom);
    @(negedge clk);
    cfg_we    <= 1'b0;
    clip_top = CLIP_W'(top);
    clip_bot = CLIP_W'(bottom);
    clip_settings++;
  endtask

  // Sender: bursts of beats separated by random gaps
  always @(negedge clk) begin : feed
    rsb_item_t nxt;
    if (rst_n) begin
      if (in_fire) void'(pending_beats.pop_front());
      if (in_tvalid && !in_fire) begin
        // hold the beat until it is taken
      end else if (idle_left > 0) begin
        idle_left--;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        nxt = pending_beats[0];
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.op;
        in_tdata  <= {4'b0, nxt.data_byte, nxt.pos_y, nxt.pos_x};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          idle_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                   : $urandom_range(0, 2);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switch between stall styles every so often
  always @(negedge clk) begin : sink
    rx_tick++;
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_left  = $urandom_range(16, 200);
    end else begin
      rx_left--;
    end
    case (rx_style)
      RX_STEADY: out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SLOW:   out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= (rx_tick % 8) > 2;
    endcase
  end

  // Predict on every taken input beat, check every taken output beat
  always @(posedge clk) begin : watch
    rsb_item_t it;
    rsb_pix_t  want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d writes outstanding", $time, expected_writes.size());
      $display("tb: failure");
      $finish;
    end
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it.op        = rsb_op_t'(in_tuser);
        it.pos_x     = in_tdata[9:0];
        it.pos_y     = in_tdata[19:10];
        it.data_byte = in_tdata[27:20];
        decode_beat(it);
        beats_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write, expected none, got addr %h value %h", $time,
                   out_tdata[19:0], out_tdata[27:20]);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          if (out_tdata[19:0] !== want.pixel_address) begin
            $display("%0t: pixel_address expected %h got %h", $time, want.pixel_address,
                     out_tdata[19:0]);
            fail_count++;
          end
          if (out_tdata[27:20] !== want.pixel_value) begin
            $display("%0t: pixel_value expected %h got %h", $time, want.pixel_value,
                     out_tdata[27:20]);
            fail_count++;
          end
          pixels_seen++;
        end
      end
    end
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  initial begin : stimulus
    int top;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bytes before any begin decode from address zero, clipped under reset bounds
    queue_byte(8'h03); queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'h80);
    // far corner, widest skip, empty literal
    queue_begin(767, 1023); queue_byte(8'h80); queue_byte(8'h00);
    // visible literal, small skip, overshooting skip, next row
    queue_begin(5, 300); queue_byte(8'h02); queue_byte(8'hAA); queue_byte(8'h55);
    queue_byte(8'hFF); queue_byte(8'hEC); queue_byte(8'h01); queue_byte(8'h7F);
    // begin cuts a literal short; exact-width skip wraps below address zero
    queue_byte(8'h05); queue_byte(8'h11);
    queue_begin(0, 0); queue_byte(8'hEA); queue_byte(8'h01); queue_byte(8'h01);

    set_clip(0, 1023);
    add_random_stream(300);
    set_clip(1023, 0);
    add_random_stream(200);
    set_clip(0, 0);
    add_random_stream(150);
    set_clip(1023, 1023);
    add_random_stream(150);
    repeat (4) begin
      top = $urandom_range(0, 1023);
      if ($urandom_range(0, 3) == 0) set_clip(top, $urandom_range(0, 1023));
      else set_clip(top, $urandom_range(top, 1023));
      add_random_stream(300);
    end
    wait_drained();

    $display("covered %0d input beats over %0d sprite starts and %0d clip settings",
             beats_taken, sprite_starts, clip_settings);
    $display("checked %0d pixel writes, %0d mismatches", pixels_seen, fail_count);
    if (fail_count == 0 && expected_writes.size() == 0) begin
      $display("tb: success");
    end else begin
      if (expected_writes.size() != 0)
        $display("%0t: %0d expected writes never arrived", $time, expected_writes.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: rle_sprite_row_blitter.f
hw/rtl/rsb_pkg.sv
hw/rtl/rsb_cfg.sv
hw/rtl/rsb_core.sv
hw/rtl/rle_sprite_row_blitter.sv
test/rle_sprite_row_blitter_test.sv
